/* rtl/sccb_pkg.sv */
`timescale 1ns / 1ps

package sccb_pkg;

	// Sequencer step codes
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_ST0  = 4'd1;
	localparam logic [3:0] PH_ST1  = 4'd2;
	localparam logic [3:0] PH_ST2  = 4'd3;
	localparam logic [3:0] PH_WB0  = 4'd4;
	localparam logic [3:0] PH_WB1  = 4'd5;
	localparam logic [3:0] PH_WB2  = 4'd6;
	localparam logic [3:0] PH_RB0  = 4'd7;
	localparam logic [3:0] PH_RB1  = 4'd8;
	localparam logic [3:0] PH_RB2  = 4'd9;
	localparam logic [3:0] PH_SP0  = 4'd10;
	localparam logic [3:0] PH_SP1  = 4'd11;
	localparam logic [3:0] PH_SP2  = 4'd12;

	// Action codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_DEV_ADDR = 2'd0;
	localparam logic [1:0] REG_QUARTER  = 2'd1;
	localparam logic [1:0] REG_HALF     = 2'd2;

	localparam logic [7:0] DEV_ADDR_RST = 8'h60;
	localparam logic [7:0] QUARTER_RST  = 8'd3;
	localparam logic [7:0] HALF_RST     = 8'd5;
	localparam logic [7:0] ADDR_WR_MASK = 8'hfe;
	localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [3:0] phase;
		logic [3:0] bit_count;
		logic [1:0] byte_count;
		logic [7:0] wait_count;
		logic [7:0] shift_out;
		logic [7:0] shift_in;
		logic [7:0] held_reg_addr;
		logic [7:0] held_write_data;
		logic [7:0] read_result;
		logic       is_read;
		logic       second_pass;
		logic       clock_level;
		logic       data_level;
		logic       data_enable;
	} sccb_state_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] quarter_ticks;
		logic [7:0] half_ticks;
	} sccb_cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} sccb_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       request_ignored;
	} sccb_result_t;

endpackage

/* rtl/sccb_step.sv */
`timescale 1ns / 1ps

module sccb_step import sccb_pkg::*; (
	input  sccb_state_t  cur,
	input  sccb_cfg_t    cfg,
	input  sccb_item_t   item,
	output sccb_state_t  nxt,
	output sccb_result_t res
);

	logic       request;
	logic       ignored;
	logic       done_now;
	logic       do_enter;
	logic       load_byte;
	logic [3:0] enter_ph;
	logic [7:0] dur;

	always_comb begin
		nxt       = cur;
		ignored   = 1'b0;
		done_now  = 1'b0;
		do_enter  = 1'b0;
		load_byte = 1'b0;
		enter_ph  = PH_IDLE;
		dur       = 8'd0;
		request   = (item.action inside {ACT_WRITE, ACT_READ});

		if (cur.phase == PH_IDLE) begin
			if (request) begin
				nxt.held_reg_addr   = item.reg_addr;
				nxt.held_write_data = item.write_data;
				nxt.is_read         = (item.action == ACT_READ);
				nxt.second_pass     = 1'b0;
				nxt.byte_count      = 2'd0;
				nxt.bit_count       = 4'd0;
				do_enter            = 1'b1;
				enter_ph            = PH_ST0;
			end
		end else begin
			ignored = request;
			if (cur.wait_count != 8'd0) begin
				nxt.wait_count = cur.wait_count - 8'd1;
			end else begin
				do_enter = 1'b1;
				case (cur.phase)
					PH_ST0: enter_ph = PH_ST1;
					PH_ST1: enter_ph = PH_ST2;
					PH_ST2: begin
						nxt.byte_count = 2'd0;
						load_byte      = 1'b1;
					end
					PH_WB0: enter_ph = PH_WB1;
					PH_WB1: enter_ph = PH_WB2;
					PH_WB2: begin
						if (cur.bit_count < BITS_PER_BYTE) begin
							nxt.bit_count = cur.bit_count + 4'd1;
							enter_ph      = PH_WB0;
						end else if (cur.second_pass) begin
							if (cur.byte_count == 2'd0) begin
								nxt.byte_count = 2'd1;
								nxt.bit_count  = 4'd0;
								nxt.shift_in   = 8'd0;
								enter_ph       = PH_RB0;
							end else begin
								enter_ph = PH_SP0;
							end
						end else begin
							nxt.byte_count = cur.byte_count + 2'd1;
							if (nxt.byte_count >= (cur.is_read ? 2'd2 : 2'd3))
								enter_ph = PH_SP0;
							else
								load_byte = 1'b1;
						end
					end
					PH_RB0: enter_ph = PH_RB1;
					PH_RB1: enter_ph = PH_RB2;
					PH_RB2: begin
						nxt.bit_count = cur.bit_count + 4'd1;
						if (nxt.bit_count >= BITS_PER_BYTE) begin
							nxt.read_result = cur.shift_in;
							nxt.bit_count   = BITS_PER_BYTE;
							enter_ph        = PH_WB0;
						end else begin
							enter_ph = PH_RB0;
						end
					end
					PH_SP0: enter_ph = PH_SP1;
					PH_SP1: enter_ph = PH_SP2;
					PH_SP2: begin
						if (cur.is_read && !cur.second_pass) begin
							nxt.second_pass = 1'b1;
							nxt.byte_count  = 2'd0;
							enter_ph        = PH_ST0;
						end else begin
							do_enter       = 1'b0;
							nxt.phase      = PH_IDLE;
							nxt.wait_count = 8'd0;
							done_now       = 1'b1;
						end
					end
					default: begin
						do_enter  = 1'b0;
						nxt.phase = PH_IDLE;
					end
				endcase
			end
		end

		// Starting a byte loads the shifter with the next address or data byte.
		if (load_byte) begin
			nxt.bit_count = 4'd0;
			enter_ph      = PH_WB0;
			if (nxt.second_pass)
				nxt.shift_out = cfg.device_address | ADDR_RD_BIT;
			else if (nxt.byte_count == 2'd0)
				nxt.shift_out = cfg.device_address & ADDR_WR_MASK;
			else if (nxt.byte_count == 2'd1)
				nxt.shift_out = nxt.held_reg_addr;
			else
				nxt.shift_out = nxt.held_write_data;
		end

		if (do_enter) begin
			dur = (enter_ph == PH_WB1 || enter_ph == PH_RB1) ?
				cfg.half_ticks : cfg.quarter_ticks;
			nxt.phase      = enter_ph;
			nxt.wait_count = (dur == 8'd0) ? 8'd0 : dur - 8'd1;
			case (enter_ph)
				PH_ST0: begin
					nxt.data_level  = 1'b1;
					nxt.clock_level = 1'b1;
				end
				PH_ST1: nxt.data_level = 1'b0;
				PH_ST2: nxt.clock_level = 1'b0;
				PH_WB0: begin
					nxt.data_enable = 1'b1;
					nxt.data_level  = (nxt.bit_count >= BITS_PER_BYTE) ? 1'b1 :
						nxt.shift_out[7];
					nxt.shift_out   = {nxt.shift_out[6:0], 1'b0};
				end
				PH_WB1: nxt.clock_level = 1'b1;
				PH_WB2: nxt.clock_level = 1'b0;
				PH_RB0: begin
					nxt.data_enable = 1'b0;
					nxt.shift_in    = {nxt.shift_in[6:0], 1'b0};
				end
				PH_RB1: nxt.clock_level = 1'b1;
				PH_RB2: nxt.clock_level = 1'b0;
				PH_SP0: nxt.data_level = 1'b0;
				PH_SP1: nxt.clock_level = 1'b1;
				PH_SP2: nxt.data_level = 1'b1;
				default: ;
			endcase
		end

		// The data line is sampled on the last tick of a clock-high read step.
		if (nxt.phase == PH_RB1 && nxt.wait_count == 8'd0 && item.sda_in)
			nxt.shift_in[0] = 1'b1;

		res.scl              = nxt.clock_level;
		res.sda_out          = nxt.data_level;
		res.sda_drive_enable = nxt.data_enable;
		res.busy_res         = (nxt.phase != PH_IDLE);
		res.done_res         = done_now;
		res.read_data        = nxt.read_result;
		res.request_ignored  = ignored;
	end

endmodule

/* rtl/sccb_register_master_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_stall    action, reg_addr, write_data, sda_in
// out       out_valid / out_stall  scl, sda_out, sda_drive_enable, busy_res,
//                                  done_res, read_data, request_ignored
// cfg       cfg_we                 cfg_index, cfg_data
//
// One request per clock cycle is taken while in_stall is low; each request is one bus tick.
// A request sits in the input register, the step logic updates the sequencer
// state and the result is registered in the output register, from which it
// is offered.
// Both registers advance together whenever the result register is empty or
// being taken; out_stall holds them and raises in_stall once the input
// register is full. Reset clears the valid flags and puts the sequencer to idle with both lines high.

module sccb_register_master_top import sccb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl,
	output logic       sda_out,
	output logic       sda_drive_enable,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       request_ignored,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	sccb_cfg_t    cfg_q;
	sccb_state_t  state_q;
	sccb_state_t  state_nxt;
	sccb_item_t   item_s1;
	sccb_result_t res_nxt;
	sccb_result_t res_s2;
	logic         valid_s1;
	logic         valid_s2;
	logic         adv;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= DEV_ADDR_RST;
			cfg_q.quarter_ticks  <= QUARTER_RST;
			cfg_q.half_ticks     <= HALF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEV_ADDR: cfg_q.device_address <= cfg_data;
				REG_QUARTER:  cfg_q.quarter_ticks  <= cfg_data;
				REG_HALF:     cfg_q.half_ticks     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action     <= action;
			item_s1.reg_addr   <= reg_addr;
			item_s1.write_data <= write_data;
			item_s1.sda_in     <= sda_in;
		end
		if (valid_s1 && adv)
			res_s2 <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_IDLE;
			state_q.bit_count       <= 4'd0;
			state_q.byte_count      <= 2'd0;
			state_q.wait_count      <= 8'd0;
			state_q.shift_out       <= 8'd0;
			state_q.shift_in        <= 8'd0;
			state_q.held_reg_addr   <= 8'd0;
			state_q.held_write_data <= 8'd0;
			state_q.read_result     <= 8'd0;
			state_q.is_read         <= 1'b0;
			state_q.second_pass     <= 1'b0;
			state_q.clock_level     <= 1'b1;
			state_q.data_level      <= 1'b1;
			state_q.data_enable     <= 1'b1;
		end else if (valid_s1 && adv) begin
			state_q <= state_nxt;
		end
	end

	sccb_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign out_valid        = valid_s2;
	assign scl              = res_s2.scl;
	assign sda_out          = res_s2.sda_out;
	assign sda_drive_enable = res_s2.sda_drive_enable;
	assign busy_res         = res_s2.busy_res;
	assign done_res         = res_s2.done_res;
	assign read_data        = res_s2.read_data;
	assign request_ignored  = res_s2.request_ignored;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import sccb_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 40;
	localparam int RANDOM_STAGES = 7;
	localparam int OPENING_COUNT = 16;

	typedef struct packed {
		sccb_item_t   req;
		logic         known;
		sccb_result_t want;
	} opening_row_t;

	localparam sccb_result_t NO_LEVELS = '0;
	localparam sccb_result_t AT_REST = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam sccb_result_t START_HIGH = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam sccb_result_t START_DROPPED = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] action = ACT_TICK;
	logic [7:0] reg_addr = 8'h00;
	logic [7:0] write_data = 8'h00;
	logic       sda_in = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       scl;
	logic       sda_out;
	logic       sda_drive_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       request_ignored;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_DEV_ADDR;
	logic [7:0] cfg_data = 8'h00;

	sccb_state_t  seq;
	sccb_cfg_t    regs;
	logic         tick_finished;
	sccb_result_t levels_due [$];
	int           failures = 0;
	int           cycles = 0;
	int           stall_left = 0;
	bit           gaps_on = 1'b1;
	bit           stalls_on = 1'b1;

	// Reset state, an unused code, then a write with busy requests piled on top.
	opening_row_t opening [OPENING_COUNT] = '{
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b0}, 1'b1, AT_REST},
		'{'{ACT_SPARE, 8'hff, 8'hff, 1'b1}, 1'b1, AT_REST},
		'{'{ACT_WRITE, 8'hff, 8'h00, 1'b0}, 1'b1, START_HIGH},
		'{'{ACT_WRITE, 8'h00, 8'hff, 1'b1}, 1'b1, START_DROPPED},
		'{'{ACT_READ, 8'h5a, 8'ha5, 1'b0}, 1'b1, START_DROPPED},
		'{'{ACT_SPARE, 8'ha5, 8'h5a, 1'b1}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, NO_LEVELS},
		'{'{ACT_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, NO_LEVELS}
	};

	sccb_register_master_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.reg_addr(reg_addr),
		.write_data(write_data),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl(scl),
		.sda_out(sda_out),
		.sda_drive_enable(sda_drive_enable),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_data(read_data),
		.request_ignored(request_ignored),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] outgoing_byte();
		if (seq.second_pass)
			return regs.device_address | ADDR_RD_BIT;
		if (seq.byte_count == 2'd0)
			return regs.device_address & ADDR_WR_MASK;
		if (seq.byte_count == 2'd1)
			return seq.held_reg_addr;
		return seq.held_write_data;
	endfunction

	function automatic void enter_step(input logic [3:0] step);
		logic [7:0] span;
		span = (step == PH_WB1 || step == PH_RB1) ? regs.half_ticks : regs.quarter_ticks;
		// A wait of zero behaves as a single tick.
		if (span == 8'd0)
			span = 8'd1;
		seq.phase = step;
		seq.wait_count = span - 8'd1;
		case (step)
			PH_ST0: begin
				seq.data_level = 1'b1;
				seq.clock_level = 1'b1;
			end
			PH_ST1: seq.data_level = 1'b0;
			PH_ST2: seq.clock_level = 1'b0;
			PH_WB0: begin
				seq.data_enable = 1'b1;
				seq.data_level = (seq.bit_count >= BITS_PER_BYTE) ? 1'b1 : seq.shift_out[7];
				seq.shift_out = {seq.shift_out[6:0], 1'b0};
			end
			PH_WB1: seq.clock_level = 1'b1;
			PH_WB2: seq.clock_level = 1'b0;
			PH_RB0: begin
				seq.data_enable = 1'b0;
				seq.shift_in = {seq.shift_in[6:0], 1'b0};
			end
			PH_RB1: seq.clock_level = 1'b1;
			PH_RB2: seq.clock_level = 1'b0;
			PH_SP0: seq.data_level = 1'b0;
			PH_SP1: seq.clock_level = 1'b1;
			PH_SP2: seq.data_level = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic void begin_byte();
		seq.bit_count = 4'd0;
		seq.shift_out = outgoing_byte();
		enter_step(PH_WB0);
	endfunction

	function automatic void next_step();
		case (seq.phase)
			PH_ST0: enter_step(PH_ST1);
			PH_ST1: enter_step(PH_ST2);
			PH_ST2: begin
				seq.byte_count = 2'd0;
				begin_byte();
			end
			PH_WB0: enter_step(PH_WB1);
			PH_WB1: enter_step(PH_WB2);
			PH_WB2: begin
				if (seq.bit_count < BITS_PER_BYTE) begin
					seq.bit_count = seq.bit_count + 4'd1;
					enter_step(PH_WB0);
				end else if (seq.second_pass) begin
					if (seq.byte_count == 2'd0) begin
						seq.byte_count = 2'd1;
						seq.bit_count = 4'd0;
						seq.shift_in = 8'h00;
						enter_step(PH_RB0);
					end else begin
						enter_step(PH_SP0);
					end
				end else begin
					seq.byte_count = seq.byte_count + 2'd1;
					if (seq.byte_count >= (seq.is_read ? 2'd2 : 2'd3))
						enter_step(PH_SP0);
					else
						begin_byte();
				end
			end
			PH_RB0: enter_step(PH_RB1);
			PH_RB1: enter_step(PH_RB2);
			PH_RB2: begin
				seq.bit_count = seq.bit_count + 4'd1;
				// After the eighth bit the ninth is sent high as a write bit.
				if (seq.bit_count >= BITS_PER_BYTE) begin
					seq.read_result = seq.shift_in;
					seq.bit_count = BITS_PER_BYTE;
					enter_step(PH_WB0);
				end else begin
					enter_step(PH_RB0);
				end
			end
			PH_SP0: enter_step(PH_SP1);
			PH_SP1: enter_step(PH_SP2);
			PH_SP2: begin
				if (seq.is_read && !seq.second_pass) begin
					seq.second_pass = 1'b1;
					seq.byte_count = 2'd0;
					enter_step(PH_ST0);
				end else begin
					seq.phase = PH_IDLE;
					seq.wait_count = 8'd0;
					tick_finished = 1'b1;
				end
			end
			default: seq.phase = PH_IDLE;
		endcase
	endfunction

	function automatic sccb_result_t bus_tick(input sccb_item_t req);
		logic         wanted;
		logic         dropped;
		sccb_result_t lines;
		wanted = (req.action == ACT_WRITE || req.action == ACT_READ);
		dropped = 1'b0;
		tick_finished = 1'b0;
		if (seq.phase == PH_IDLE) begin
			if (wanted) begin
				seq.held_reg_addr = req.reg_addr;
				seq.held_write_data = req.write_data;
				seq.is_read = (req.action == ACT_READ);
				seq.second_pass = 1'b0;
				seq.byte_count = 2'd0;
				seq.bit_count = 4'd0;
				enter_step(PH_ST0);
			end
		end else begin
			dropped = wanted;
			if (seq.wait_count > 8'd0)
				seq.wait_count = seq.wait_count - 8'd1;
			else
				next_step();
		end
		// The data line is sampled on the last tick of clock high.
		if (seq.phase == PH_RB1 && seq.wait_count == 8'd0 && req.sda_in)
			seq.shift_in[0] = 1'b1;
		lines.scl = seq.clock_level;
		lines.sda_out = seq.data_level;
		lines.sda_drive_enable = seq.data_enable;
		lines.busy_res = (seq.phase != PH_IDLE);
		lines.done_res = tick_finished;
		lines.read_data = seq.read_result;
		lines.request_ignored = dropped;
		return lines;
	endfunction

	function automatic sccb_item_t choose_request();
		sccb_item_t req;
		int         roll;
		logic       closing;
		req.reg_addr = 8'($urandom_range(0, 255));
		req.write_data = 8'($urandom_range(0, 255));
		req.sda_in = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 19);
		closing = seq.phase == PH_SP2 && seq.wait_count == 8'd0 &&
			!(seq.is_read && !seq.second_pass);
		if (seq.phase == PH_IDLE)
			req.action = (roll < 14) ? (roll[0] ? ACT_WRITE : ACT_READ) :
				((roll < 17) ? ACT_TICK : ACT_SPARE);
		else if (closing)
			req.action = (roll < 10) ? (roll[0] ? ACT_WRITE : ACT_READ) : ACT_TICK;
		else if (roll == 0)
			req.action = ACT_WRITE;
		else if (roll == 1)
			req.action = ACT_READ;
		else if (roll == 2)
			req.action = ACT_SPARE;
		else
			req.action = ACT_TICK;
		return req;
	endfunction

	function automatic int stage_length(input int stage);
		if (stage == 4)
			return 120;
		if (stage == 6)
			return 250;
		return 175;
	endfunction

	task automatic offer_request(input sccb_item_t req, input logic known,
			input sccb_result_t want);
		int           gap;
		sccb_result_t lines;
		gap = gaps_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= req.action;
		reg_addr <= req.reg_addr;
		write_data <= req.write_data;
		sda_in <= req.sda_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		lines = bus_tick(req);
		levels_due.push_back(known ? want : lines);
	endtask

	// The caller lowers the write enable once the last register is written.
	task automatic set_register(input logic [1:0] index, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		if (index == REG_DEV_ADDR)
			regs.device_address = value;
		else if (index == REG_QUARTER)
			regs.quarter_ticks = value;
		else if (index == REG_HALF)
			regs.half_ticks = value;
	endtask

	task automatic apply_settings(input int stage);
		logic [7:0] dev;
		logic [7:0] quarter;
		logic [7:0] half;
		dev = 8'($urandom_range(0, 255));
		quarter = 8'd1;
		half = 8'd1;
		case (stage)
			1: begin
				dev = 8'hff;
				quarter = 8'd0;
				half = 8'd0;
			end
			2: begin
				dev = 8'h00;
				quarter = 8'd2;
			end
			3: half = 8'd3;
			4: begin
				quarter = 8'hff;
				half = 8'hff;
			end
			6: begin
				quarter = 8'($urandom_range(1, 3));
				half = 8'($urandom_range(1, 3));
			end
			default: ;
		endcase
		set_register(REG_DEV_ADDR, dev);
		set_register(REG_QUARTER, quarter);
		set_register(REG_HALF, half);
		cfg_we <= 1'b0;
	endtask

	function automatic void compare_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		sccb_result_t want;
		if (out_valid && !out_stall) begin
			if (levels_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: result expected none, got scl %0b sda %0b busy %0b",
						$time, scl, sda_out, busy_res);
			end else begin
				want = levels_due.pop_front();
				compare_field("scl", 8'(want.scl), 8'(scl));
				compare_field("sda_out", 8'(want.sda_out), 8'(sda_out));
				compare_field("sda_drive_enable", 8'(want.sda_drive_enable),
					8'(sda_drive_enable));
				compare_field("busy_res", 8'(want.busy_res), 8'(busy_res));
				compare_field("done_res", 8'(want.done_res), 8'(done_res));
				compare_field("read_data", want.read_data, read_data);
				compare_field("request_ignored", 8'(want.request_ignored),
					8'(request_ignored));
			end
			stall_left = stalls_on ? $urandom_range(0, 10) : 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		seq = '0;
		seq.phase = PH_IDLE;
		seq.clock_level = 1'b1;
		seq.data_level = 1'b1;
		seq.data_enable = 1'b1;
		regs = '{DEV_ADDR_RST, QUARTER_RST, HALF_RST};
		tick_finished = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			offer_request(opening[i].req, opening[i].known, opening[i].want);
		// Settings change with the bus possibly mid-transaction, which is allowed.
		for (int stage = 0; stage < RANDOM_STAGES; stage++) begin
			in_valid <= 1'b0;
			while (levels_due.size() != 0)
				@(posedge clk);
			apply_settings(stage);
			for (int k = 0; k < stage_length(stage); k++) begin
				if (k % 50 == 0) begin
					gaps_on = ($urandom_range(0, 2) != 0);
					stalls_on = ($urandom_range(0, 2) != 0);
				end
				offer_request(choose_request(), 1'b0, NO_LEVELS);
			end
		end
		in_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
